[src/split_access_load_store_unit_assert.svh]
// Assertion macros for the split access load/store unit.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef SPLIT_ACCESS_LOAD_STORE_UNIT_ASSERT_SVH
`define SPLIT_ACCESS_LOAD_STORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SALSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SALSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SALSU_ASSERT(lbl, prop, msg)
`define SALSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/salsu_pkg.sv]
package salsu_pkg;

  // Operation codes carried by each request.
  typedef enum logic [2:0] {
    OP_PUSH_READ  = 3'd0,
    OP_PUSH_WRITE = 3'd1,
    OP_RETRY      = 3'd2,
    OP_RESPONSE   = 3'd3,
    OP_RELEASE    = 3'd4
  } op_e;

  // Access phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_PENDING  = 3'b010,
    PH_COMPLETE = 3'b100
  } phase_e;

  // Encoded phase as reported to the user.
  localparam logic [1:0] PHASE_CODE_IDLE     = 2'd0;
  localparam logic [1:0] PHASE_CODE_PENDING  = 2'd1;
  localparam logic [1:0] PHASE_CODE_COMPLETE = 2'd2;

  // Legal range and reset value of the line size register.
  localparam logic [3:0] LINE_LOG2_MIN   = 4'd3;
  localparam logic [3:0] LINE_LOG2_MAX   = 4'd10;
  localparam logic [3:0] LINE_LOG2_RESET = 4'd6;

  // Mask that keeps the low n bytes of a 64-bit word.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Convert the one-hot phase to its reported code.
  function automatic logic [1:0] phase_code(input phase_e p);
    logic [1:0] c;
    unique case (p)
      PH_PENDING:  c = PHASE_CODE_PENDING;
      PH_COMPLETE: c = PHASE_CODE_COMPLETE;
      default:     c = PHASE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

[src/split_access_load_store_unit.sv]
// A request is captured in the input register, and its result is then held in the result register.
// Throughput: one request per cycle; the input register and result register each take a
// new request whenever the stage ahead of them moves or is empty.
// Reset (rst_ni low, asynchronous): unit idle, counter and flags cleared, line size 2^6 bytes,
// both pipeline registers empty.
`include "split_access_load_store_unit_assert.svh"

module split_access_load_store_unit
  import salsu_pkg::*;
#(
  parameter int MAX_ACCESS_BYTES = 8,
  parameter int ADDR_WIDTH       = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration.
  input  logic                  cfg_we_i,
  input  logic [3:0]            cfg_data_i,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            operation_i,
  input  logic [ADDR_WIDTH-1:0] address_i,
  input  logic [3:0]            access_size_i,
  input  logic [63:0]           write_data_i,
  input  logic [63:0]           response_data_i,
  input  logic                  port_accepts_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  request_valid_o,
  output logic                  request_is_write_o,
  output logic [ADDR_WIDTH-1:0] request_address_o,
  output logic [3:0]            request_size_o,
  output logic [63:0]           request_data_o,
  output logic                  done_res_o,
  output logic [63:0]           read_data_o,
  output logic [31:0]           completion_count_o,
  output logic [1:0]            phase_o,
  output logic                  waiting_for_retry_o,
  output logic                  error_o
);

  localparam logic [3:0] MaxBytes = 4'(MAX_ACCESS_BYTES);

  // Configuration register.
  logic [3:0] line_log2_q;

  // Input register.
  logic                  in_valid_q;
  logic [2:0]            op_q;
  logic [ADDR_WIDTH-1:0] addr_in_q;
  logic [3:0]            size_in_q;
  logic [63:0]           wdata_in_q;
  logic [63:0]           resp_in_q;
  logic                  accepts_q;

  // Access state.
  phase_e                phase_q, phase_d;
  logic                  split_q, split_d;
  logic                  second_q, second_d;
  logic [3:0]            head_q, head_d;
  logic [3:0]            tail_q, tail_d;
  logic                  write_q, write_d;
  logic [ADDR_WIDTH-1:0] saved_addr_q, saved_addr_d;
  logic [3:0]            saved_size_q, saved_size_d;
  logic [63:0]           saved_wdata_q, saved_wdata_d;
  logic [63:0]           asm_q, asm_d;
  logic                  retry_q, retry_d;
  logic [31:0]           count_q, count_d;

  // Result register.
  logic                  out_valid_q;
  logic                  req_valid_q, req_valid_d;
  logic                  req_write_q, req_write_d;
  logic [ADDR_WIDTH-1:0] req_addr_q, req_addr_d;
  logic [3:0]            req_size_q, req_size_d;
  logic [63:0]           req_data_q, req_data_d;
  logic                  done_q, done_d;
  logic [63:0]           rdata_q, rdata_d;
  logic                  err_q, err_d;

  logic out_ready;
  logic fire;

  // The result register moves when empty or drained; the input register feeds it.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_log2_q <= LINE_LOG2_RESET;
    end else if (cfg_we_i) begin
      line_log2_q <= cfg_data_i;
    end
  end

  // Input register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q       <= operation_i;
      addr_in_q  <= address_i;
      size_in_q  <= access_size_i;
      wdata_in_q <= write_data_i;
      resp_in_q  <= response_data_i;
      accepts_q  <= port_accepts_i;
    end
  end

  // One pass over the buffered request: update the access state, then describe the
  // request that is presented to the cache from the updated state.
  always_comb begin
    logic [3:0]  lg;
    logic [3:0]  n;
    logic [10:0] line;
    logic [10:0] room;
    logic        present;
    logic [63:0] d;
    logic [3:0]  rn;

    phase_d       = phase_q;
    split_d       = split_q;
    second_d      = second_q;
    head_d        = head_q;
    tail_d        = tail_q;
    write_d       = write_q;
    saved_addr_d  = saved_addr_q;
    saved_size_d  = saved_size_q;
    saved_wdata_d = saved_wdata_q;
    asm_d         = asm_q;
    retry_d       = retry_q;
    count_d       = count_q;
    present       = 1'b0;
    done_d        = 1'b0;
    err_d         = 1'b0;

    // Clamp the line size and the access size to their legal ranges.
    lg = line_log2_q;
    if (lg < LINE_LOG2_MIN) lg = LINE_LOG2_MIN;
    if (lg > LINE_LOG2_MAX) lg = LINE_LOG2_MAX;
    n = size_in_q;
    if (n == 4'd0) n = 4'd1;
    if (n > MaxBytes) n = MaxBytes;
    line = 11'(1) << lg;
    room = line - (addr_in_q[10:0] & (line - 11'd1));

    unique case (op_q) inside
      OP_PUSH_READ, OP_PUSH_WRITE: begin
        if (phase_q != PH_IDLE) begin
          err_d = 1'b1;
        end else begin
          saved_addr_d  = addr_in_q;
          saved_size_d  = n;
          write_d       = (op_q == OP_PUSH_WRITE);
          saved_wdata_d = write_d ? (wdata_in_q & byte_mask(n)) : '0;
          asm_d         = '0;
          if ({7'd0, n} <= room) begin
            split_d = 1'b0;
            head_d  = 4'd0;
            tail_d  = 4'd0;
          end else begin
            split_d = 1'b1;
            head_d  = room[3:0];
            tail_d  = n - room[3:0];
          end
          second_d = 1'b0;
          phase_d  = PH_PENDING;
          present  = 1'b1;
        end
      end
      OP_RETRY: begin
        if (phase_q == PH_PENDING && retry_q) begin
          present = 1'b1;
        end
      end
      OP_RESPONSE: begin
        if (phase_q != PH_PENDING || retry_q) begin
          err_d = 1'b1;
        end else if (split_q && !second_q) begin
          // Head part answered: keep its bytes and send the tail part.
          if (!write_q) begin
            asm_d = resp_in_q & byte_mask(head_q);
          end
          second_d = 1'b1;
          present  = 1'b1;
        end else begin
          if (!write_q) begin
            if (split_q) begin
              asm_d = asm_q | ((resp_in_q & byte_mask(tail_q)) << {head_q[2:0], 3'b000});
            end else begin
              asm_d = resp_in_q & byte_mask(saved_size_q);
            end
          end
          phase_d = PH_COMPLETE;
          count_d = count_q + 32'd1;
          done_d  = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (phase_q != PH_COMPLETE) begin
          err_d = 1'b1;
        end else begin
          phase_d  = PH_IDLE;
          split_d  = 1'b0;
          second_d = 1'b0;
          head_d   = 4'd0;
          tail_d   = 4'd0;
          retry_d  = 1'b0;
        end
      end
      default: begin
        err_d = 1'b1;
      end
    endcase

    // Describe the in-flight request: whole access, head part or tail part.
    if (split_d && second_d) begin
      req_addr_d = saved_addr_d + ADDR_WIDTH'(head_d);
      rn         = tail_d;
      d          = saved_wdata_d >> {head_d[2:0], 3'b000};
    end else begin
      req_addr_d = saved_addr_d;
      rn         = split_d ? head_d : saved_size_d;
      d          = saved_wdata_d;
    end

    req_valid_d = present;
    req_write_d = present && write_d;
    if (!present) req_addr_d = '0;
    req_size_d  = present ? rn : 4'd0;
    req_data_d  = (present && write_d) ? (d & byte_mask(rn)) : '0;
    if (present) retry_d = !accepts_q;

    rdata_d = (done_d && !write_d) ? (asm_d & byte_mask(saved_size_d)) : '0;
  end

  // Access control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      split_q  <= 1'b0;
      second_q <= 1'b0;
      head_q   <= 4'd0;
      tail_q   <= 4'd0;
      write_q  <= 1'b0;
      asm_q    <= '0;
      retry_q  <= 1'b0;
      count_q  <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      split_q  <= split_d;
      second_q <= second_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      write_q  <= write_d;
      asm_q    <= asm_d;
      retry_q  <= retry_d;
      count_q  <= count_d;
    end
  end

  // Latched access, written by every push before it is read.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      saved_addr_q  <= saved_addr_d;
      saved_size_q  <= saved_size_d;
      saved_wdata_q <= saved_wdata_d;
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fire;
    end
  end

  // Result register payload; state fields are taken from the updated state.
  logic [31:0] count_res_q;
  logic [1:0]  phase_res_q;
  logic        retry_res_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      req_valid_q <= req_valid_d;
      req_write_q <= req_write_d;
      req_addr_q  <= req_addr_d;
      req_size_q  <= req_size_d;
      req_data_q  <= req_data_d;
      done_q      <= done_d;
      rdata_q     <= rdata_d;
      count_res_q <= count_d;
      phase_res_q <= phase_code(phase_d);
      retry_res_q <= retry_d;
      err_q       <= err_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign request_valid_o     = req_valid_q;
  assign request_is_write_o  = req_write_q;
  assign request_address_o   = req_addr_q;
  assign request_size_o      = req_size_q;
  assign request_data_o      = req_data_q;
  assign done_res_o          = done_q;
  assign read_data_o         = rdata_q;
  assign completion_count_o  = count_res_q;
  assign phase_o             = phase_res_q;
  assign waiting_for_retry_o = retry_res_q;
  assign error_o             = err_q;

  // A refused request can only exist while an access is pending.
  `SALSU_ASSERT(a_retry_pending, !retry_q || phase_q == PH_PENDING, "retry flag outside pending")
  // The tail phase exists only for a split access, and the parts add up to its size.
  `SALSU_ASSERT(a_second_split, !second_q || split_q, "second half without split")
  `SALSU_ASSERT(a_split_sizes, !split_q || (head_q + tail_q == saved_size_q && head_q != 4'd0),
                "split parts do not cover the access")
  // Every completion bumps the counter by exactly one.
  `SALSU_ASSERT_NEXT(a_count_step, fire && done_d, count_q == $past(count_q) + 32'd1,
                     "completion counter did not advance")
  // A completion result always reports the complete phase.
  `SALSU_ASSERT(a_done_phase, !(out_valid_q && done_q) || phase_res_q == PHASE_CODE_COMPLETE,
                "done reported outside complete phase")

endmodule

[test/lsu_result_checker.sv]
module lsu_result_checker
  import salsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  operation_i,
  input  logic [47:0] address_i,
  input  logic [3:0]  access_size_i,
  input  logic [63:0] write_data_i,
  input  logic [63:0] response_data_i,
  input  logic        port_accepts_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        request_valid_i,
  input  logic        request_is_write_i,
  input  logic [47:0] request_address_i,
  input  logic [3:0]  request_size_i,
  input  logic [63:0] request_data_i,
  input  logic        done_res_i,
  input  logic [63:0] read_data_i,
  input  logic [31:0] completion_count_i,
  input  logic [1:0]  phase_i,
  input  logic        waiting_for_retry_i,
  input  logic        error_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] ACCESS_BYTES_MAX = 4'd8;
  localparam int         MAX_REPORTS      = 10;

  // Everything the unit reports for one request.
  typedef struct packed {
    logic        req_valid;
    logic        req_write;
    logic [47:0] req_addr;
    logic [3:0]  req_size;
    logic [63:0] req_data;
    logic        done;
    logic [63:0] read_data;
    logic [31:0] count;
    logic [1:0]  phase;
    logic        wait_retry;
    logic        error;
  } unit_result_t;

  // Shadow copy of the unit's registers.
  logic [3:0]  line_log2_q;
  logic [1:0]  phase_q;
  logic        split_q;
  logic        second_q;
  logic [3:0]  head_q;
  logic [3:0]  tail_q;
  logic        write_q;
  logic [47:0] base_addr_q;
  logic [3:0]  size_q;
  logic [63:0] store_bytes_q;
  logic [63:0] gathered_q;
  logic        refused_q;
  logic [31:0] completed_q;

  unit_result_t awaited_results_q[$];

  function automatic logic [63:0] lane_mask(input logic [3:0] n);
    return (n >= 4'd8) ? '1 : ((64'd1 << {n, 3'b000}) - 64'd1);
  endfunction

  function automatic void clear_unit();
    line_log2_q   = LINE_LOG2_RESET;
    phase_q       = PHASE_CODE_IDLE;
    split_q       = 1'b0;
    second_q      = 1'b0;
    head_q        = '0;
    tail_q        = '0;
    write_q       = 1'b0;
    base_addr_q   = '0;
    size_q        = '0;
    store_bytes_q = '0;
    gathered_q    = '0;
    refused_q     = 1'b0;
    completed_q   = '0;
  endfunction

  // Presents the part of the access that is in flight: the head, the tail or all of it.
  function automatic void issue_request(inout unit_result_t r, input logic acc);
    logic [47:0] a;
    logic [3:0]  n;
    logic [63:0] d;
    a = base_addr_q;
    n = size_q;
    d = store_bytes_q;
    if (split_q) begin
      if (second_q) begin
        a = base_addr_q + 48'(head_q);
        n = tail_q;
        d = store_bytes_q >> {head_q, 3'b000};
      end else begin
        n = head_q;
      end
    end
    r.req_valid = 1'b1;
    r.req_write = write_q;
    r.req_addr  = a;
    r.req_size  = n;
    r.req_data  = write_q ? (d & lane_mask(n)) : '0;
    refused_q   = !acc;
  endfunction

  // Advances the shadow state by one request and returns what the unit must report.
  function automatic unit_result_t next_unit_result(input logic [2:0] op,
                                                    input logic [47:0] addr,
                                                    input logic [3:0] size,
                                                    input logic [63:0] wdata,
                                                    input logic [63:0] rdata,
                                                    input logic acc);
    unit_result_t r;
    logic [3:0]   lg;
    logic [3:0]   n;
    logic [63:0]  line_bytes;
    logic [63:0]  room;
    logic         finish;
    r = '0;
    case (op) inside
      OP_PUSH_READ, OP_PUSH_WRITE: begin
        if (phase_q != PHASE_CODE_IDLE) begin
          r.error = 1'b1;
        end else begin
          lg = line_log2_q;
          if (lg < LINE_LOG2_MIN) lg = LINE_LOG2_MIN;
          else if (lg > LINE_LOG2_MAX) lg = LINE_LOG2_MAX;
          n = size;
          if (n == 4'd0) n = 4'd1;
          else if (n > ACCESS_BYTES_MAX) n = ACCESS_BYTES_MAX;
          base_addr_q   = addr;
          size_q        = n;
          write_q       = (op == OP_PUSH_WRITE);
          store_bytes_q = write_q ? (wdata & lane_mask(n)) : '0;
          gathered_q    = '0;
          line_bytes    = 64'd1 << lg;
          room          = line_bytes - (64'(addr) & (line_bytes - 64'd1));
          // An access that runs past the end of its line goes out as head and tail.
          if (64'(n) <= room) begin
            split_q = 1'b0;
            head_q  = '0;
            tail_q  = '0;
          end else begin
            split_q = 1'b1;
            head_q  = room[3:0];
            tail_q  = n - room[3:0];
          end
          second_q = 1'b0;
          phase_q  = PHASE_CODE_PENDING;
          issue_request(r, acc);
        end
      end
      OP_RETRY: begin
        // A retry with nothing refused is silently dropped.
        if (phase_q == PHASE_CODE_PENDING && refused_q) issue_request(r, acc);
      end
      OP_RESPONSE: begin
        if (phase_q != PHASE_CODE_PENDING || refused_q) begin
          r.error = 1'b1;
        end else begin
          finish = 1'b1;
          if (split_q && !second_q) begin
            if (!write_q) gathered_q = rdata & lane_mask(head_q);
            second_q = 1'b1;
            finish   = 1'b0;
            issue_request(r, acc);
          end else if (split_q) begin
            if (!write_q) gathered_q |= (rdata & lane_mask(tail_q)) << {head_q, 3'b000};
          end else if (!write_q) begin
            gathered_q = rdata & lane_mask(size_q);
          end
          if (finish) begin
            phase_q     = PHASE_CODE_COMPLETE;
            completed_q = completed_q + 32'd1;
            r.done      = 1'b1;
            r.read_data = write_q ? '0 : (gathered_q & lane_mask(size_q));
          end
        end
      end
      OP_RELEASE: begin
        if (phase_q != PHASE_CODE_COMPLETE) begin
          r.error = 1'b1;
        end else begin
          phase_q   = PHASE_CODE_IDLE;
          split_q   = 1'b0;
          second_q  = 1'b0;
          head_q    = '0;
          tail_q    = '0;
          refused_q = 1'b0;
        end
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    r.count      = completed_q;
    r.phase      = phase_q;
    r.wait_retry = refused_q;
    return r;
  endfunction

  function automatic string describe(input unit_result_t r);
    return {$sformatf("req=%0b wr=%0b addr=%h size=%0d data=%h ", r.req_valid, r.req_write,
                      r.req_addr, r.req_size, r.req_data),
            $sformatf("done=%0b rdata=%h cnt=%0d ph=%0d rt=%0b err=%0b", r.done, r.read_data,
                      r.count, r.phase, r.wait_retry, r.error)};
  endfunction

  // Compare finished results first, then predict for a newly accepted request.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    unit_result_t seen;
    unit_result_t want;
    if (!rst_ni) begin
      clear_unit();
      awaited_results_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) line_log2_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        seen = '{request_valid_i, request_is_write_i, request_address_i, request_size_i,
                 request_data_i, done_res_i, read_data_i, completion_count_i, phase_i,
                 waiting_for_retry_i, error_i};
        if (awaited_results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: result with no request outstanding: %s", $time, describe(seen));
        end else begin
          want = awaited_results_q.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results_q.push_back(next_unit_result(operation_i, address_i, access_size_i,
                                                     write_data_i, response_data_i,
                                                     port_accepts_i));
      end
      pending_o = awaited_results_q.size();
    end
  end

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import salsu_pkg::*;

  localparam int PHASE_ITEMS    = 100;
  localparam int LINE_PHASES    = 6;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_AT        = 560;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int OP_CODE_SPACE  = 8;
  localparam int NOISE_PCT      = 15;

  // Where the unit stands, for picking a request that it has to reject or ignore.
  localparam int CTX_IDLE     = 0;
  localparam int CTX_ACCEPTED = 1;
  localparam int CTX_REFUSED  = 2;
  localparam int CTX_DONE     = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [47:0] address = '0;
  logic [3:0]  access_size = '0;
  logic [63:0] write_data = '0;
  logic [63:0] response_data = '0;
  logic        port_accepts = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        request_valid;
  logic        request_is_write;
  logic [47:0] request_address;
  logic [3:0]  request_size;
  logic [63:0] request_data;
  logic        done_res;
  logic [63:0] read_data;
  logic [31:0] completion_count;
  logic [1:0]  phase;
  logic        waiting_for_retry;
  logic        error;

  int          fail_count;
  int          pending;
  int          sent_items = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  logic [3:0]  line_log2 = LINE_LOG2_RESET;

  split_access_load_store_unit u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .address_i          (address),
    .access_size_i      (access_size),
    .write_data_i       (write_data),
    .response_data_i    (response_data),
    .port_accepts_i     (port_accepts),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .request_valid_o    (request_valid),
    .request_is_write_o (request_is_write),
    .request_address_o  (request_address),
    .request_size_o     (request_size),
    .request_data_o     (request_data),
    .done_res_o         (done_res),
    .read_data_o        (read_data),
    .completion_count_o (completion_count),
    .phase_o            (phase),
    .waiting_for_retry_o(waiting_for_retry),
    .error_o            (error)
  );

  lsu_result_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .operation_i        (operation),
    .address_i          (address),
    .access_size_i      (access_size),
    .write_data_i       (write_data),
    .response_data_i    (response_data),
    .port_accepts_i     (port_accepts),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .request_valid_i    (request_valid),
    .request_is_write_i (request_is_write),
    .request_address_i  (request_address),
    .request_size_i     (request_size),
    .request_data_i     (request_data),
    .done_res_i         (done_res),
    .read_data_i        (read_data),
    .completion_count_i (completion_count),
    .phase_i            (phase),
    .waiting_for_retry_i(waiting_for_retry),
    .error_i            (error),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  always #5 clk = ~clk;

  // The run ends if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The result side stalls in random bursts, once for a long stretch, and not at the end.
  initial begin
    logic val;
    int   span;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_taken) begin
        val        = 1'b1;
        span       = HOLD_CYCLES;
        hold_taken = 1'b1;
      end else if (calm) begin
        val  = 1'b0;
        span = 1;
      end else begin
        val  = ($urandom_range(0, 2) == 0);
        span = val ? $urandom_range(1, 16) : $urandom_range(1, 40);
      end
      @(posedge clk);
      out_stall <= val;
      repeat (span - 1) @(posedge clk);
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] line_bytes();
    logic [3:0] lg;
    lg = line_log2;
    if (lg < LINE_LOG2_MIN) lg = LINE_LOG2_MIN;
    else if (lg > LINE_LOG2_MAX) lg = LINE_LOG2_MAX;
    return 64'd1 << lg;
  endfunction

  // Tells whether an access will go out as a head and a tail part.
  function automatic bit crosses_line(input logic [47:0] addr, input logic [3:0] size);
    logic [3:0]  n;
    logic [63:0] line;
    n = size;
    if (n == 4'd0) n = 4'd1;
    else if (n > 4'd8) n = 4'd8;
    line = line_bytes();
    return 64'(n) > (line - (64'(addr) & (line - 64'd1)));
  endfunction

  // Offers one request, sometimes with a random gap ahead of it, and waits until it is taken.
  task automatic send_item(input logic [2:0] op, input logic [47:0] addr,
                           input logic [3:0] size, input logic [63:0] wdata,
                           input logic [63:0] rdata, input logic acc);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    address       <= addr;
    access_size   <= size;
    write_data    <= wdata;
    response_data <= rdata;
    port_accepts  <= acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    if (sent_items == HOLD_AT) hold_req = 1'b1;
    calm = (sent_items >= CALM_AT);
  endtask

  task automatic send_op(input logic [2:0] op, input logic acc);
    send_item(op, rand48(), 4'($urandom_range(0, 15)), rand64(), rand64(), acc);
  endtask

  // With a chance of pct percent, sends a request that the unit must reject or drop in its present phase.
  task automatic maybe_noise(input int ctx, input int pct);
    logic [2:0] op;
    if ($urandom_range(0, 99) < pct) begin
      op = 3'($urandom_range(0, OP_CODE_SPACE - 1));
      while ((ctx == CTX_IDLE && (op == OP_PUSH_READ || op == OP_PUSH_WRITE)) ||
             (ctx == CTX_ACCEPTED && op == OP_RESPONSE) ||
             (ctx == CTX_REFUSED && op == OP_RETRY) ||
             (ctx == CTX_DONE && op == OP_RELEASE))
        op = 3'($urandom_range(0, OP_CODE_SPACE - 1));
      send_op(op, 1'($urandom_range(0, 1)));
    end
  endtask

  // Retries a refused cache request until the cache takes it.
  task automatic settle_request(input logic acc, input int pct);
    logic taken;
    taken = acc;
    maybe_noise(taken ? CTX_ACCEPTED : CTX_REFUSED, pct);
    while (!taken) begin
      taken = ($urandom_range(0, 2) != 0);
      send_op(OP_RETRY, taken);
      maybe_noise(taken ? CTX_ACCEPTED : CTX_REFUSED, pct);
    end
  endtask

  // One complete access: push, retries, one or two responses, release.
  task automatic do_access(input logic is_write, input logic [47:0] addr,
                           input logic [3:0] size, input logic [63:0] wdata,
                           input bit refuse_first, input int pct);
    logic acc;
    bit   two_parts;
    two_parts = crosses_line(addr, size);
    acc = refuse_first ? 1'b0 : ($urandom_range(0, 3) != 0);
    send_item(is_write ? OP_PUSH_WRITE : OP_PUSH_READ, addr, size, wdata, rand64(), acc);
    settle_request(acc, pct);
    if (two_parts) begin
      acc = refuse_first ? 1'b0 : ($urandom_range(0, 3) != 0);
      send_op(OP_RESPONSE, acc);
      settle_request(acc, pct);
    end
    send_op(OP_RESPONSE, 1'($urandom_range(0, 1)));
    maybe_noise(CTX_DONE, pct);
    send_op(OP_RELEASE, 1'($urandom_range(0, 1)));
    maybe_noise(CTX_IDLE, pct);
  endtask

  // Random access, often placed at a line end or at the top of the address space.
  task automatic random_access(input int pct);
    logic [47:0] addr;
    logic [3:0]  size;
    logic [63:0] line;
    line = line_bytes();
    if ($urandom_range(0, 9) == 0) size = 4'($urandom_range(0, 15));
    else size = 4'($urandom_range(1, 8));
    case ($urandom_range(0, 3))
      0:       addr = 48'((64'(rand48()) & ~(line - 64'd1)) | (line - $urandom_range(1, 8)));
      1:       addr = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 7));
      default: addr = rand48();
    endcase
    do_access(1'($urandom_range(0, 1)), addr, size, rand64(), $urandom_range(0, 7) == 0, pct);
  endtask

  // Stops offering requests and waits until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_size(input logic [3:0] val);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    line_log2 = val;
  endtask

  initial begin
    int         phase_start;
    logic [3:0] val;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed accesses at the reset line size of 64 bytes.
    do_access(1'b0, 48'h0, 4'd8, 64'h0, 1'b0, 0);
    do_access(1'b0, 48'hFFFF_FFFF_FFFC, 4'd8, 64'h0, 1'b1, 0);
    do_access(1'b1, 48'h0000_0000_003F, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0);
    do_access(1'b1, 48'h0000_0000_1000, 4'd0, 64'hA5A5_5A5A_0123_4567, 1'b0, 0);
    do_access(1'b0, 48'h0000_0000_0038, 4'd15, 64'h0, 1'b0, 0);
    // Requests that an idle unit has to reject or drop, and the unused codes.
    send_op(OP_RETRY, 1'b1);
    send_op(OP_RESPONSE, 1'b1);
    send_op(OP_RELEASE, 1'b0);
    for (int k = int'(OP_RELEASE) + 1; k < OP_CODE_SPACE; k++) send_op(3'(k), 1'b1);

    // Random traffic under several line sizes, the extremes and the saturating ones first.
    phase_start = sent_items;
    for (int p = 0; p < LINE_PHASES; p++) begin
      case (p)
        0:       val = LINE_LOG2_MIN;
        1:       val = LINE_LOG2_MAX;
        2:       val = 4'h0;
        3:       val = 4'hF;
        default: val = 4'($urandom_range(0, 15));
      endcase
      set_line_size(val);
      while (sent_items < phase_start + (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0) begin
          repeat ($urandom_range(1, 3))
            send_op(3'($urandom_range(0, OP_CODE_SPACE - 1)), 1'($urandom_range(0, 1)));
        end else begin
          random_access(NOISE_PCT);
        end
      end
    end

    drain_results();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/salsu_pkg.sv
src/split_access_load_store_unit.sv
test/lsu_result_checker.sv
test/tb_top.sv
